// ----- rtl/evt3_pkg.sv -----
// Shared types and constants of the EVT 3.0 event stream decoder.
package evt3_pkg;

  localparam int unsigned WordW     = 16;
  localparam int unsigned PayW      = 12;
  localparam int unsigned TimeW     = 12;
  localparam int unsigned RollW     = 24;
  localparam int unsigned StampW    = 48;
  localparam int unsigned RowW      = 11;
  localparam int unsigned XW        = 16;
  localparam int unsigned MaskW     = 12;
  localparam int unsigned IdxW      = $clog2(MaskW);
  localparam int unsigned SpanBig   = 12;
  localparam int unsigned SpanSmall = 8;

  localparam logic [TimeW-1:0] FullBase    = 12'hFFF;
  localparam logic [TimeW-1:0] MarginReset = 12'd10;

  // word type codes
  localparam logic [3:0] WT_ADDR_Y      = 4'h0;
  localparam logic [3:0] WT_ADDR_X      = 4'h2;
  localparam logic [3:0] WT_VECT_BASE_X = 4'h3;
  localparam logic [3:0] WT_VECT_12     = 4'h4;
  localparam logic [3:0] WT_VECT_8      = 4'h5;
  localparam logic [3:0] WT_TIME_LOW    = 4'h6;
  localparam logic [3:0] WT_CONTINUED_4 = 4'h7;
  localparam logic [3:0] WT_TIME_HIGH   = 4'h8;
  localparam logic [3:0] WT_EXT_TRIGGER = 4'hA;
  localparam logic [3:0] WT_OTHERS      = 4'hE;
  localparam logic [3:0] WT_CONTINUED_12 = 4'hF;

  typedef enum logic [1:0] {
    KIND_PIXEL       = 2'd0,
    KIND_TRIGGER     = 2'd1,
    KIND_UNSUPPORTED = 2'd2
  } kind_e;

  // everything needed to expand one word into its results
  typedef struct packed {
    kind_e             kind;
    logic [StampW-1:0] stamp;
    logic [XW-1:0]     base_x;
    logic [RowW-1:0]   row;
    logic              pol;
    logic              trig_edge;
    logic [3:0]        trig_chan;
    logic [MaskW-1:0]  mask;
  } bundle_t;

endpackage

// ----- rtl/evt3_decode.sv -----
// Decoder state (row, time, rollover, vector base) and per-word bundle build.
module evt3_decode (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [evt3_pkg::TimeW-1:0]  cfg_wdata_i,
  input  logic                        accept_i,
  input  logic [evt3_pkg::WordW-1:0]  word_i,
  output evt3_pkg::bundle_t           bundle_o,
  output logic                        has_result_o
);

  logic [evt3_pkg::TimeW-1:0] margin_q;
  logic [evt3_pkg::RowW-1:0]  row_q, row_d;
  logic [evt3_pkg::TimeW-1:0] tl_q, tl_d;
  logic [evt3_pkg::TimeW-1:0] th_q, th_d;
  logic [evt3_pkg::RollW-1:0] roll_q, roll_d;
  logic [evt3_pkg::XW-1:0]    bx_q, bx_d;
  logic                       vpol_q, vpol_d;

  logic [3:0]                 code;
  logic [evt3_pkg::PayW-1:0]  pay;
  logic [evt3_pkg::TimeW-1:0] th_diff;

  assign code    = word_i[15:12];
  assign pay     = word_i[evt3_pkg::PayW-1:0];
  assign th_diff = th_q - pay;

  always_comb begin
    row_d  = row_q;
    tl_d   = tl_q;
    th_d   = th_q;
    roll_d = roll_q;
    bx_d   = bx_q;
    vpol_d = vpol_q;

    bundle_o.kind      = evt3_pkg::KIND_PIXEL;
    bundle_o.stamp     = {roll_q, th_q, tl_q};
    bundle_o.base_x    = '0;
    bundle_o.row       = '0;
    bundle_o.pol       = 1'b0;
    bundle_o.trig_edge = 1'b0;
    bundle_o.trig_chan = '0;
    bundle_o.mask      = '0;

    unique case (code) inside
      evt3_pkg::WT_ADDR_Y: begin
        row_d = pay[evt3_pkg::RowW-1:0];
      end
      evt3_pkg::WT_ADDR_X: begin
        bundle_o.base_x = {5'b0, pay[10:0]};
        bundle_o.row    = row_q;
        bundle_o.pol    = pay[11];
        bundle_o.mask   = evt3_pkg::MaskW'(1);
      end
      evt3_pkg::WT_VECT_BASE_X: begin
        bx_d   = {5'b0, pay[10:0]};
        vpol_d = pay[11];
      end
      evt3_pkg::WT_VECT_12: begin
        bundle_o.base_x = bx_q;
        bundle_o.row    = row_q;
        bundle_o.pol    = vpol_q;
        bundle_o.mask   = pay;
        bx_d            = bx_q + evt3_pkg::XW'(evt3_pkg::SpanBig);
      end
      evt3_pkg::WT_VECT_8: begin
        bundle_o.base_x = bx_q;
        bundle_o.row    = row_q;
        bundle_o.pol    = vpol_q;
        bundle_o.mask   = {4'b0, pay[7:0]};
        bx_d            = bx_q + evt3_pkg::XW'(evt3_pkg::SpanSmall);
      end
      evt3_pkg::WT_TIME_LOW: begin
        tl_d = pay;
      end
      evt3_pkg::WT_TIME_HIGH: begin
        if ((th_q > pay) && (th_diff >= (evt3_pkg::FullBase - margin_q))) begin
          roll_d = roll_q + evt3_pkg::RollW'(1);
        end
        th_d = pay;
        tl_d = '0;
      end
      evt3_pkg::WT_EXT_TRIGGER: begin
        bundle_o.kind      = evt3_pkg::KIND_TRIGGER;
        bundle_o.trig_edge = pay[0];
        bundle_o.trig_chan = pay[11:8];
        bundle_o.mask      = evt3_pkg::MaskW'(1);
      end
      evt3_pkg::WT_CONTINUED_4, evt3_pkg::WT_OTHERS, evt3_pkg::WT_CONTINUED_12: begin
      end
      default: begin
        bundle_o.kind  = evt3_pkg::KIND_UNSUPPORTED;
        bundle_o.stamp = '0;
        bundle_o.mask  = evt3_pkg::MaskW'(1);
      end
    endcase
  end

  assign has_result_o = (bundle_o.mask != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_q <= evt3_pkg::MarginReset;
    end else if (cfg_we_i) begin
      margin_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      tl_q   <= '0;
      th_q   <= '0;
      roll_q <= '0;
      bx_q   <= '0;
      vpol_q <= 1'b0;
    end else if (accept_i) begin
      row_q  <= row_d;
      tl_q   <= tl_d;
      th_q   <= th_d;
      roll_q <= roll_d;
      bx_q   <= bx_d;
      vpol_q <= vpol_d;
    end
  end

endmodule

// ----- rtl/evt3_expand.sv -----
// Bundle slot and result register: emits one result per set mask bit.
module evt3_expand (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         load_i,
  input  evt3_pkg::bundle_t            bundle_i,
  output logic                         slot_free_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   result_kind_o,
  output logic [evt3_pkg::StampW-1:0]  timestamp_o,
  output logic [evt3_pkg::XW-1:0]      pixel_x_o,
  output logic [evt3_pkg::RowW-1:0]    pixel_y_o,
  output logic                         polarity_o,
  output logic                         trigger_edge_o,
  output logic [3:0]                   trigger_channel_o,
  output logic                         last_of_word_o
);

  evt3_pkg::bundle_t            bnd_q;
  logic                         bvalid_q;
  logic                         out_valid_q;
  evt3_pkg::kind_e              kind_q;
  logic [evt3_pkg::StampW-1:0]  stamp_q;
  logic [evt3_pkg::XW-1:0]      x_q;
  logic [evt3_pkg::RowW-1:0]    y_q;
  logic                         pol_q;
  logic                         edge_q;
  logic [3:0]                   chan_q;
  logic                         last_q;

  logic                         out_load;
  logic                         pop;
  logic [evt3_pkg::IdxW-1:0]    idx;
  logic [evt3_pkg::MaskW-1:0]   rest;
  logic                         last;

  // lowest set bit of the remaining mask
  always_comb begin
    idx = '0;
    for (int i = evt3_pkg::MaskW - 1; i >= 0; i--) begin
      if (bnd_q.mask[i]) idx = evt3_pkg::IdxW'(i);
    end
  end

  assign rest        = bnd_q.mask & (bnd_q.mask - evt3_pkg::MaskW'(1));
  assign last        = (rest == '0);
  assign out_load    = !out_valid_q || !out_stall_i;
  assign pop         = bvalid_q && out_load;
  assign slot_free_o = !bvalid_q || (pop && last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_i) begin
        bvalid_q <= 1'b1;
      end else if (pop && last) begin
        bvalid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= bvalid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bnd_q <= bundle_i;
    end else if (pop) begin
      bnd_q.mask <= rest;
    end
    if (pop) begin
      kind_q  <= bnd_q.kind;
      stamp_q <= bnd_q.stamp;
      x_q     <= bnd_q.base_x + evt3_pkg::XW'(idx);
      y_q     <= bnd_q.row;
      pol_q   <= bnd_q.pol;
      edge_q  <= bnd_q.trig_edge;
      chan_q  <= bnd_q.trig_chan;
      last_q  <= last;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign result_kind_o     = kind_q;
  assign timestamp_o       = stamp_q;
  assign pixel_x_o         = x_q;
  assign pixel_y_o         = y_q;
  assign polarity_o        = pol_q;
  assign trigger_edge_o    = edge_q;
  assign trigger_channel_o = chan_q;
  assign last_of_word_o    = last_q;

  a_slot_has_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bvalid_q |-> (bnd_q.mask != '0))
    else $error("bundle slot held with empty mask");

  a_single_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (kind_q != evt3_pkg::KIND_PIXEL)) |-> last_q)
    else $error("trigger or error result not marked last");

  a_keep_partial: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !last) |=> bvalid_q)
    else $error("bundle dropped with bits left");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> slot_free_o)
    else $error("bundle loaded into occupied slot");

endmodule

// ----- rtl/evt3_event_stream_decoder.sv -----
// Top level of the EVT 3.0 event stream decoder.
// Accepts one 16-bit EVT 3.0 word per cycle while in_stall is low. State words
// (row, time, vector base) update at once; each word with events is decoded in
// the accept cycle into a bundle slot, which feeds one registered result per
// cycle while out_stall is low. ADDR_X, trigger and unsupported words thus
// sustain one word per cycle while out_stall is low; a vector word stalls the
// input until all of its set valid bits but the last are emitted (up to 12
// results, the last flagged by last_of_word). rollover_margin may be written
// only while the block is idle.
module evt3_event_stream_decoder (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [evt3_pkg::TimeW-1:0]   cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [evt3_pkg::WordW-1:0]   stream_word_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   result_kind_o,
  output logic [evt3_pkg::StampW-1:0]  timestamp_o,
  output logic [evt3_pkg::XW-1:0]      pixel_x_o,
  output logic [evt3_pkg::RowW-1:0]    pixel_y_o,
  output logic                         polarity_o,
  output logic                         trigger_edge_o,
  output logic [3:0]                   trigger_channel_o,
  output logic                         last_of_word_o
);

  evt3_pkg::bundle_t bundle;
  logic              has_result;
  logic              slot_free;
  logic              accept;

  assign in_stall_o = !slot_free;
  assign accept     = in_valid_i && slot_free;

  evt3_decode u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .accept_i     (accept),
    .word_i       (stream_word_i),
    .bundle_o     (bundle),
    .has_result_o (has_result)
  );

  evt3_expand u_expand (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .load_i            (accept && has_result),
    .bundle_i          (bundle),
    .slot_free_o       (slot_free),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .result_kind_o     (result_kind_o),
    .timestamp_o       (timestamp_o),
    .pixel_x_o         (pixel_x_o),
    .pixel_y_o         (pixel_y_o),
    .polarity_o        (polarity_o),
    .trigger_edge_o    (trigger_edge_o),
    .trigger_channel_o (trigger_channel_o),
    .last_of_word_o    (last_of_word_o)
  );

endmodule
